>>> sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// types, constants and codes shared by the timer table modules
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int SRC_W = 5;
	localparam logic [31:0] CLOCK_RESET = 32'd46875000;
	localparam logic [47:0] MIN_DELAY_US = 48'd1000;
	localparam logic [47:0] T48_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [19:0] US_PER_SEC = 20'd1000000;

	localparam logic [1:0] FUNC_SET = 2'd0;
	localparam logic [1:0] FUNC_STOP = 2'd1;
	localparam logic [1:0] FUNC_CHECK = 2'd2;
	// unused code, the table ignores it
	localparam logic [1:0] FUNC_NOP = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] handle_id;
		logic [39:0] countdown_cycles;
		logic [39:0] interval_cycles;
		logic [7:0] queue_id;
		logic [31:0] message_token;
		logic [47:0] now_us;
	} stt_in_t;

	typedef struct packed {
		logic [7:0] dest_queue;
		logic [31:0] fired_message;
		logic [SRC_W-1:0] source_slot;
		logic last;
	} stt_out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV_D, ST_DIV_P, ST_SET_SCAN, ST_SET_ARM, ST_SET_EMIT,
		ST_STOP, ST_CHK_RD, ST_CHK_EVAL, ST_FLUSH
	} stt_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture request
		logic div_start;   // start conversion
		logic div_sel_p;   // 0 countdown, 1 interval
		logic scan_clr;    // reset slot index
		logic set_scan;    // cancel/free search step
		logic arm;         // write free slot
		logic stop_all;    // free matching slots
		logic chk_eval;    // evaluate current slot
		logic idx_inc;
		logic emit_imm;    // immediate result
		logic flush;       // mark pending result last
	} stt_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic short_delay;
		logic free_found;
		logic idx_last;
		logic [1:0] func;
		logic out_busy;
		logic pend_valid;
	} stt_sts_t;

endpackage

>>> sv/stt_div.sv
// ----------------------------------------------------------------------------
// stt_div
// restoring divider: cycles * 1e6 / rate, one quotient bit per cycle
// ----------------------------------------------------------------------------
module stt_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [39:0] cycles,
	input logic [31:0] rate,
	output logic busy,
	output logic [47:0] quot
);
	import stt_pkg::*;

	logic [59:0] num_q;
	logic [59:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [5:0] cnt_q;
	logic [32:0] trial;
	logic [32:0] sh;

	assign sh = {rem_q, num_q[59]};
	assign trial = sh - {1'b0, den_q};
	assign busy = cnt_q != 6'd0;
	// saturate above 48 bits
	assign quot = (quo_q[59:48] != 12'd0) ? T48_MAX : quo_q[47:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd60;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {20'd0, cycles} * {40'd0, US_PER_SEC};
			rem_q <= '0;
			quo_q <= '0;
			den_q <= (rate == 32'd0) ? 32'd1 : rate;
		end else if (busy) begin
			num_q <= {num_q[58:0], 1'b0};
			// remainder stays below the divisor, so 32 bits hold it
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[58:0], 1'b1};
			end else begin
				rem_q <= sh[31:0];
				quo_q <= {quo_q[58:0], 1'b0};
			end
		end
	end
endmodule

>>> sv/stt_datapath.sv
// ----------------------------------------------------------------------------
// stt_datapath
// slot table, request registers, converter and output register
// ----------------------------------------------------------------------------
module stt_datapath (
	input logic clk,
	input logic arst_n,
	input stt_pkg::stt_in_t req,
	input logic [31:0] rate,
	input stt_pkg::stt_cmd_t cmd,
	output stt_pkg::stt_sts_t sts,
	output logic out_valid,
	input logic out_stall,
	output stt_pkg::stt_out_t out_data
);
	import stt_pkg::*;

	stt_in_t req_q;
	logic [47:0] delay_q, period_q;
	logic [NUM_SLOTS-1:0] active_q;
	logic [7:0] handle_q [NUM_SLOTS];
	logic [7:0] queue_q [NUM_SLOTS];
	logic [47:0] expiry_q [NUM_SLOTS];
	logic [47:0] per_q [NUM_SLOTS];
	logic [31:0] msg_q [NUM_SLOTS];
	logic [SLOT_W-1:0] idx_q, free_q;
	logic free_found_q;
	logic div_busy, div_start;
	logic [47:0] quot;
	logic [39:0] div_in;
	// pending result, held back until we know whether it is last
	stt_out_t pend_q;
	stt_out_t pend_last;
	logic pend_valid_q;
	logic out_valid_q;
	stt_out_t out_q;
	logic [48:0] sum;
	logic [47:0] exp_new;
	logic cur_hit;
	logic push;
	stt_out_t push_d;

	assign div_in = cmd.div_sel_p ? req_q.interval_cycles : req_q.countdown_cycles;
	assign div_start = cmd.div_start;

	stt_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .cycles(div_in),
		.rate(rate), .busy(div_busy), .quot(quot)
	);

	// expiry adder, operand chosen by operation
	always_comb begin
		if (req_q.func == FUNC_CHECK) sum = {1'b0, req_q.now_us} + {1'b0, per_q[idx_q]};
		else sum = {1'b0, req_q.now_us} + {1'b0, delay_q};
		exp_new = sum[48] ? T48_MAX : sum[47:0];
	end

	assign cur_hit = active_q[idx_q] && (req_q.now_us >= expiry_q[idx_q]);

	always_comb begin
		push = 1'b0;
		push_d = '0;
		if (cmd.emit_imm) begin
			push = req_q.queue_id != 8'd0;
			push_d.dest_queue = req_q.queue_id;
			push_d.fired_message = req_q.message_token;
			push_d.source_slot = SRC_W'(NUM_SLOTS);
		end else if (cmd.chk_eval && cur_hit) begin
			push = queue_q[idx_q] != 8'd0;
			push_d.dest_queue = queue_q[idx_q];
			push_d.fired_message = msg_q[idx_q];
			push_d.source_slot = SRC_W'(idx_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (!div_busy && !cmd.div_start && cmd.div_sel_p) period_q <= quot;
		// countdown result is complete when the interval conversion starts
		if (cmd.div_start && cmd.div_sel_p) delay_q <= quot;
		if (cmd.arm) begin
			expiry_q[free_q] <= exp_new;
			per_q[free_q] <= period_q;
			msg_q[free_q] <= req_q.message_token;
		end
		if (cmd.chk_eval && cur_hit && per_q[idx_q] != 48'd0) expiry_q[idx_q] <= exp_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				handle_q[i] <= '0;
				queue_q[i] <= '0;
			end
			idx_q <= '0;
			free_q <= '0;
			free_found_q <= 1'b0;
		end else begin
			if (cmd.scan_clr) begin
				idx_q <= '0;
				free_found_q <= 1'b0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
			if (cmd.set_scan) begin
				if (active_q[idx_q] && handle_q[idx_q] == req_q.handle_id) begin
					active_q[idx_q] <= 1'b0;
					if (!free_found_q) begin
						free_found_q <= 1'b1;
						free_q <= idx_q;
					end
				end else if (!active_q[idx_q] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_q <= idx_q;
				end
			end
			if (cmd.arm) begin
				active_q[free_q] <= 1'b1;
				handle_q[free_q] <= req_q.handle_id;
				queue_q[free_q] <= req_q.queue_id;
			end
			if (cmd.stop_all) begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (active_q[i] && handle_q[i] == req_q.handle_id) begin
						active_q[i] <= 1'b0;
						handle_q[i] <= '0;
						queue_q[i] <= '0;
					end
				end
			end
			if (cmd.chk_eval && cur_hit && per_q[idx_q] == 48'd0) begin
				active_q[idx_q] <= 1'b0;
				handle_q[idx_q] <= '0;
				queue_q[idx_q] <= '0;
			end
		end
	end

	// pending result with last set, for the final flush
	always_comb begin
		pend_last = pend_q;
		pend_last.last = 1'b1;
	end

	// pending and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (push) begin
				// controller only pushes when the output is free
				if (pend_valid_q) out_valid_q <= 1'b1;
				pend_valid_q <= 1'b1;
			end else if (cmd.flush && pend_valid_q) begin
				out_valid_q <= 1'b1;
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pend_q <= push_d;
			if (pend_valid_q) out_q <= pend_q;
		end else if (cmd.flush && pend_valid_q) begin
			out_q <= pend_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		sts.div_busy = div_busy;
		sts.short_delay = delay_q < MIN_DELAY_US;
		sts.free_found = free_found_q;
		sts.idx_last = idx_q == SLOT_W'(NUM_SLOTS - 1);
		sts.func = req_q.func;
		sts.out_busy = out_valid_q && out_stall;
		sts.pend_valid = pend_valid_q;
	end
endmodule

>>> sv/stt_ctrl.sv
// ----------------------------------------------------------------------------
// stt_ctrl
// sequencer for set, stop and check requests
// ----------------------------------------------------------------------------
module stt_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input stt_pkg::stt_sts_t sts,
	output stt_pkg::stt_cmd_t cmd,
	output logic idle
);
	import stt_pkg::*;

	stt_state_t state_q, state_d;
	logic div_go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_go_q <= 1'b0;
		end else begin
			state_q <= state_d;
			div_go_q <= state_q != state_d &&
				(state_d == ST_DIV_D || state_d == ST_DIV_P);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_FLUSH;
			ST_FLUSH: begin
				// in the cycle after capture: dispatch
				unique case (sts.func)
					FUNC_SET: state_d = ST_DIV_D;
					FUNC_STOP: state_d = ST_STOP;
					FUNC_CHECK: state_d = ST_CHK_EVAL;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_DIV_D: if (!div_go_q && !sts.div_busy) state_d = ST_DIV_P;
			ST_DIV_P: begin
				if (!div_go_q && !sts.div_busy) begin
					if (sts.short_delay) state_d = ST_SET_EMIT;
					else state_d = ST_SET_SCAN;
				end
			end
			ST_SET_SCAN: if (sts.idx_last) state_d = ST_SET_ARM;
			ST_SET_ARM: begin
				if (sts.free_found) state_d = ST_CHK_RD;
				else state_d = ST_SET_EMIT;
			end
			ST_SET_EMIT: if (!sts.out_busy) state_d = ST_CHK_RD;
			ST_STOP: state_d = ST_CHK_RD;
			ST_CHK_EVAL: if (!sts.out_busy && sts.idx_last) state_d = ST_CHK_RD;
			// drain: mark last pending result
			ST_CHK_RD: if (!sts.out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		idle = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				cmd.load = in_fire;
			end
			ST_FLUSH: cmd.scan_clr = 1'b1;
			ST_DIV_D: cmd.div_start = div_go_q;
			ST_DIV_P: begin
				cmd.div_sel_p = 1'b1;
				cmd.div_start = div_go_q;
			end
			ST_SET_SCAN: begin
				cmd.set_scan = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			ST_SET_ARM: cmd.arm = sts.free_found;
			ST_SET_EMIT: cmd.emit_imm = !sts.out_busy;
			ST_STOP: cmd.stop_all = 1'b1;
			ST_CHK_EVAL: begin
				cmd.chk_eval = !sts.out_busy;
				cmd.idx_inc = !sts.out_busy;
			end
			ST_CHK_RD: cmd.flush = !sts.out_busy;
			default: ;
		endcase
	end
endmodule

>>> sv/software_timer_table.sv
// ----------------------------------------------------------------------------
// software_timer_table
// sixteen-slot timer table with set, stop and check requests
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid / in_stall carry one request (stt_in_t); a request
//   is taken when in_valid is high and in_stall low, one at a time
//   out channel: out_valid / out_stall carry fired messages (stt_out_t),
//   last set on the final result of a request; a request may give none
//   cfg channel: cfg_valid / cfg_ready write clock_rate_hz, idle only by the user; not enforced
// timing
//   set: two conversions on the shared 60-step divider, then a scan of
//   all slots, an arm state and a drain state; with a short delay the
//   scan and arm give way to an immediate result; stop frees every matching
//   slot in a single state, then drains; check evaluates one slot per cycle
//   while the output is not stalled, then drains; results leave through
//   a one-deep pending register so last can be marked, then the output register
// reset
//   all slots free, clock rate back to 46875000
// stall
//   while out_stall holds a result, the check scan, emit and drain wait; no result is dropped
// ----------------------------------------------------------------------------
module software_timer_table (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input stt_pkg::stt_in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output stt_pkg::stt_out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [31:0] cfg_data
);
	import stt_pkg::*;

	logic [31:0] rate_q;
	stt_cmd_t cmd;
	stt_sts_t sts;
	logic idle;
	logic in_fire;

	// request accepted only when the sequencer is idle
	assign in_stall = !idle;
	assign in_fire = in_valid && idle;
	assign cfg_ready = 1'b1;

	// clock rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rate_q <= CLOCK_RESET;
		else if (cfg_valid && cfg_ready) rate_q <= cfg_data;
	end

	stt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .sts(sts), .cmd(cmd), .idle(idle)
	);

	stt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .req(in_data), .rate(rate_q), .cmd(cmd), .sts(sts),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	// nothing pending once idle
	assert property (@(posedge clk) disable iff (!arst_n)
		idle |-> !sts.pend_valid)
		else $error("pending result left behind");

	// no push while the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.out_busy |-> !cmd.emit_imm && !cmd.chk_eval)
		else $error("push under stall");
endmodule
